### design/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/gccc_pkg.sv
package gccc_pkg;

  // Number of row registers in the configuration space.
  localparam int ROW_REGS = 4;

  // Default number of half-plane rows tested.
  localparam int PLANE_ROWS_DEFAULT = 4;

  // Register stages from input beat to output beat.
  localparam int NUM_STAGES = 8;

  // Width of a counter that can hold the number of items in flight.
  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  // Configuration register index width and register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROW3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY_SCALE = 3'd4;

endpackage

### design/gaussian_collision_chance_check.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    two means and two covariances
// out       output     out_valid / out_ready  safe, proving_row
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data (64 bits)
//
// One item per cycle is accepted while in_ready is high; each result passes
// through every register stage of the eight-stage pipeline.
// Wide products (margin squared, quadratic form times scale squared) are cut
// into partial products in one stage and summed in the next.
// Reset clears the valid bits and every configuration register to zero.
// A stalled output holds its beat; each stage only waits when the next is
// full and not moving, so bubbles close up and no beat is lost or repeated.
module gaussian_collision_chance_check #(
  parameter int PLANE_ROWS = gccc_pkg::PLANE_ROWS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [23:0]             mean_a_x,
  input  logic signed [23:0]             mean_a_y,
  input  logic        [22:0]             cov_a_xx,
  input  logic signed [23:0]             cov_a_xy,
  input  logic        [22:0]             cov_a_yy,
  input  logic signed [23:0]             mean_b_x,
  input  logic signed [23:0]             mean_b_y,
  input  logic        [22:0]             cov_b_xx,
  input  logic signed [23:0]             cov_b_xy,
  input  logic        [22:0]             cov_b_yy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           safe,
  output logic        [1:0]              proving_row,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gccc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  // Rows actually tested: never more than the row registers.
  localparam int LANES = (PLANE_ROWS < gccc_pkg::ROW_REGS) ? PLANE_ROWS
                                                           : gccc_pkg::ROW_REGS;
  localparam int NS = gccc_pkg::NUM_STAGES;

  // Configuration registers.
  logic [63:0] plane_row [gccc_pkg::ROW_REGS];
  logic [15:0] safety_scale;

  // Stage valid bits and advance enables.
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  // Unpacked row coefficients.
  logic signed [19:0] row_a [LANES];
  logic signed [19:0] row_b [LANES];
  logic signed [23:0] row_c [LANES];

  // Stage 1: relative mean and summed covariance.
  logic signed [24:0] s1_mx, s1_my, s1_sxy;
  logic        [23:0] s1_sxx, s1_syy;

  // Stage 2: first products.
  logic signed [44:0] s2_pa [LANES];
  logic signed [44:0] s2_pb [LANES];
  logic        [38:0] s2_aa [LANES];
  logic        [38:0] s2_bb [LANES];
  logic signed [39:0] s2_ab [LANES];
  logic signed [24:0] s2_sxy;
  logic        [23:0] s2_sxx, s2_syy;

  // Stage 3: margin and quadratic form terms.
  logic signed [47:0] s3_lhs [LANES];
  logic        [62:0] s3_qx  [LANES];
  logic        [62:0] s3_qy  [LANES];
  logic signed [63:0] s3_qc  [LANES];

  // Stage 4: quadratic form and squared scale.
  logic signed [65:0] s4_q   [LANES];
  logic signed [47:0] s4_lhs [LANES];
  logic        [31:0] s4_kk;

  // Stage 5: partial products of both squared sides.
  logic        [45:0] s5_lhh [LANES];
  logic        [46:0] s5_lhl [LANES];
  logic        [47:0] s5_lll [LANES];
  logic        [64:0] s5_qhk [LANES];
  logic        [63:0] s5_qlk [LANES];
  logic [LANES-1:0]   s5_ok;

  // Stage 6: both sides assembled.
  logic        [93:0] s6_lsq [LANES];
  logic        [96:0] s6_rhs [LANES];
  logic [LANES-1:0]   s6_ok;

  // Stage 7: per-row verdict.
  logic [LANES-1:0]   s7_pass;

  // Lowest passing row.
  logic               pick_safe;
  logic [1:0]         pick_row;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gccc_pkg::ROW_REGS; i++) begin
        plane_row[i] <= '0;
      end
      safety_scale <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gccc_pkg::REG_PLANE_ROW0:   plane_row[0] <= cfg_data;
        gccc_pkg::REG_PLANE_ROW1:   plane_row[1] <= cfg_data;
        gccc_pkg::REG_PLANE_ROW2:   plane_row[2] <= cfg_data;
        gccc_pkg::REG_PLANE_ROW3:   plane_row[3] <= cfg_data;
        gccc_pkg::REG_SAFETY_SCALE: safety_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Split each row register into its coefficients.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      row_a[l] = $signed(plane_row[l][19:0]);
      row_b[l] = $signed(plane_row[l][39:20]);
      row_c[l] = $signed(plane_row[l][63:40]);
    end
  end

  // A stage may load when it is empty or its beat moves on.
  always_comb begin
    adv[NS-1] = !v[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end

  assign in_ready = adv[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // Stage 1: differences and sums of the two beliefs.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_mx  <= 25'(mean_a_x) - 25'(mean_b_x);
      s1_my  <= 25'(mean_a_y) - 25'(mean_b_y);
      s1_sxy <= 25'(cov_a_xy) + 25'(cov_b_xy);
      s1_sxx <= 24'(cov_a_xx) + 24'(cov_b_xx);
      s1_syy <= 24'(cov_a_yy) + 24'(cov_b_yy);
    end
  end

  // Stage 2: coefficient products with the mean and with each other.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int l = 0; l < LANES; l++) begin
        s2_pa[l] <= 45'(row_a[l]) * 45'(s1_mx);
        s2_pb[l] <= 45'(row_b[l]) * 45'(s1_my);
        s2_aa[l] <= 39'(row_a[l]) * 39'(row_a[l]);
        s2_bb[l] <= 39'(row_b[l]) * 39'(row_b[l]);
        s2_ab[l] <= 40'(row_a[l]) * 40'(row_b[l]);
      end
      s2_sxy <= s1_sxy;
      s2_sxx <= s1_sxx;
      s2_syy <= s1_syy;
    end
  end

  // Stage 3: margin a*mx + b*my - c, and the three covariance terms.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int l = 0; l < LANES; l++) begin
        s3_lhs[l] <= 48'(s2_pa[l]) + 48'(s2_pb[l]) - 48'($signed({row_c[l], 8'b0}));
        s3_qx[l]  <= 63'(s2_aa[l]) * 63'(s2_sxx);
        s3_qy[l]  <= 63'(s2_bb[l]) * 63'(s2_syy);
        s3_qc[l]  <= 64'(s2_ab[l]) * 64'(s2_sxy);
      end
    end
  end

  // Stage 4: quadratic form q'Sq, and k squared.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int l = 0; l < LANES; l++) begin
        s4_q[l]   <= $signed({3'b0, s3_qx[l]}) + $signed({3'b0, s3_qy[l]})
                     + 66'($signed({s3_qc[l], 1'b0}));
        s4_lhs[l] <= s3_lhs[l];
      end
      s4_kk <= 32'(safety_scale) * 32'(safety_scale);
    end
  end

  // Stage 5: partial products; a negative margin or form fails the row.
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int l = 0; l < LANES; l++) begin
        s5_ok[l]  <= !s4_q[l][65] && !s4_lhs[l][47];
        s5_lhh[l] <= 46'(s4_lhs[l][46:24]) * 46'(s4_lhs[l][46:24]);
        s5_lhl[l] <= 47'(s4_lhs[l][46:24]) * 47'(s4_lhs[l][23:0]);
        s5_lll[l] <= 48'(s4_lhs[l][23:0]) * 48'(s4_lhs[l][23:0]);
        s5_qhk[l] <= 65'(s4_q[l][64:32]) * 65'(s4_kk);
        s5_qlk[l] <= 64'(s4_q[l][31:0]) * 64'(s4_kk);
      end
    end
  end

  // Stage 6: margin squared and scaled form, both exact.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int l = 0; l < LANES; l++) begin
        s6_lsq[l] <= {s5_lhh[l], 48'b0} + {22'b0, s5_lhl[l], 25'b0}
                     + {46'b0, s5_lll[l]};
        s6_rhs[l] <= {s5_qhk[l], 32'b0} + {33'b0, s5_qlk[l]};
      end
      s6_ok <= s5_ok;
    end
  end

  // Stage 7: compare at a common scale of 48 fraction bits.
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int l = 0; l < LANES; l++) begin
        s7_pass[l] <= s6_ok[l] && ({s6_lsq[l], 16'b0} >= {13'b0, s6_rhs[l]});
      end
    end
  end

  // Lowest row that passes wins; the row reads zero when none passes.
  always_comb begin
    pick_safe = 1'b0;
    pick_row  = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (s7_pass[l]) begin
        pick_safe = 1'b1;
        pick_row  = 2'(l);
      end
    end
  end

  // Stage 8: output register.
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      safe        <= pick_safe;
      proving_row <= pick_row;
    end
  end

  assign out_valid = v[NS-1];

endmodule

### design/gccc_checker.sv
`include "assert_macros.svh"

module gccc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       safe,
  input logic [1:0] proving_row
);

  // Beats taken in but not yet delivered.
  logic [gccc_pkg::CNT_W-1:0] outstanding;
  logic [gccc_pkg::CNT_W-1:0] outstanding_next;
  logic                       in_beat;
  logic                       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    outstanding_next = outstanding + gccc_pkg::CNT_W'(in_beat)
                       - gccc_pkg::CNT_W'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding_next;
    end
  end

  // A result is only offered for an item that was taken in.
  `ASSERT_IMPLIES(a_out_has_item, clk, rst, out_valid, outstanding != '0, "result with no item")

  // No more items in flight than there are pipeline stages.
  `ASSERT_ALWAYS(a_depth, clk, rst, outstanding <= gccc_pkg::NUM_STAGES, "too many items in flight")

  // An unsafe verdict always reports row zero.
  `ASSERT_IMPLIES(a_row_zero, clk, rst, out_valid && !safe, proving_row == 2'd0, "row set while unsafe")

  // A stalled result holds its beat.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(safe) && $stable(proving_row), "stalled result changed")

endmodule

bind gaussian_collision_chance_check gccc_checker u_gccc_checker (.*);
